/* hw/rtl/relay_switch_time_meter_top_assert.svh */
// Assertion macros for the relay switching-time meter RTL.
`ifndef RELAY_SWITCH_TIME_METER_TOP_ASSERT_SVH
`define RELAY_SWITCH_TIME_METER_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, checked outside reset.
`define RSTM_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, checked outside reset.
`define RSTM_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define RSTM_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define RSTM_ASSERT_NXT(label, clk, rst, ante, cons, msg)
`endif
`endif

/* hw/rtl/rstm_pkg.sv */
// Shared types, constants and microprogram of the relay switching-time meter.
`timescale 1ns / 1ps
`default_nettype none
package rstm_pkg;

  // Field and register widths.
  localparam int TimeW    = 20;
  localparam int TimerW   = 21;
  localparam int SumW     = 28;
  localparam int CountW   = 8;
  localparam int UpcW     = 5;
  localparam int DivCntW  = 5;
  localparam int CondN    = 16;
  localparam int AddrW    = 4;
  localparam int DataW    = 32;

  // Register reset values.
  localparam logic [TimeW-1:0]  TimeoutReset = 20'd500000;
  localparam logic [TimerW-1:0] SettleReset  = 21'd100000;
  localparam logic [TimerW-1:0] PauseReset   = 21'd1000000;
  localparam logic [CountW-1:0] BatchReset   = 8'd10;

  // Last step index of the divide loop (one quotient bit per step).
  localparam logic [DivCntW-1:0] DivLast = DivCntW'(SumW - 1);

  // Register indexes on the configuration port.
  typedef enum logic [1:0] {
    REG_TIMEOUT = 2'd0,
    REG_SETTLE  = 2'd1,
    REG_PAUSE   = 2'd2,
    REG_BATCH   = 2'd3
  } rstm_reg_t;

  // Report kinds.
  typedef enum logic [1:0] {
    REP_NONE    = 2'd0,
    REP_CYCLE   = 2'd1,
    REP_TIMEOUT = 2'd2,
    REP_MEAN    = 2'd3
  } rstm_rep_t;

  // Datapath micro-operations.
  typedef enum logic [4:0] {
    OP_NOP,
    OP_LATCH,
    OP_ENTER_ON,
    OP_ENTER_SETTLE,
    OP_ENTER_OFF,
    OP_ENTER_PAUSE,
    OP_REC_ON,
    OP_SET_ONTO,
    OP_REC_OFF,
    OP_SET_OFFTO,
    OP_ACCUM,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_EMIT_NONE,
    OP_EMIT_TO,
    OP_EMIT_CYC_LAST,
    OP_EMIT_CYC_MORE,
    OP_EMIT_MEAN
  } rstm_op_t;

  // Branch conditions, each one bit of the status flag vector.
  typedef enum logic [3:0] {
    C_ALWAYS,
    C_IN_VALID,
    C_PH_ON,
    C_PH_SETTLE,
    C_PH_OFF,
    C_FALL,
    C_RISE,
    C_TMR_GE_TO,
    C_TMR_GE_SETTLE,
    C_TMR_GE_PAUSE,
    C_SETTLE_ZERO,
    C_PAUSE_ZERO,
    C_ERR,
    C_BATCH,
    C_DIV_LAST
  } rstm_cond_t;

  // One control word of the microprogram.
  typedef struct packed {
    rstm_op_t         op;
    rstm_cond_t       cond;
    logic             inv;
    logic             take;
    logic [UpcW-1:0]  target;
  } rstm_uword_t;

  // Control from sequencer to datapath.
  typedef struct packed {
    rstm_op_t op;
    logic     take;
  } rstm_ctl_t;

  // Status from datapath to sequencer.
  typedef struct packed {
    logic [CondN-1:0] flags;
    logic             out_free;
  } rstm_stat_t;

  // Configuration register values.
  typedef struct packed {
    logic [TimeW-1:0]  timeout_ticks;
    logic [TimerW-1:0] settle_ticks;
    logic [TimerW-1:0] pause_ticks;
    logic [CountW-1:0] batch_size;
  } rstm_cfg_t;

  // Microprogram labels.
  localparam logic [UpcW-1:0] L_FETCH    = 5'd0;
  localparam logic [UpcW-1:0] L_ON       = 5'd6;
  localparam logic [UpcW-1:0] L_ON_TO    = 5'd8;
  localparam logic [UpcW-1:0] L_E_SETTLE = 5'd10;
  localparam logic [UpcW-1:0] L_SETTLE   = 5'd12;
  localparam logic [UpcW-1:0] L_OFF      = 5'd14;
  localparam logic [UpcW-1:0] L_OFF_TO   = 5'd16;
  localparam logic [UpcW-1:0] L_E_PAUSE  = 5'd18;
  localparam logic [UpcW-1:0] L_CHECK    = 5'd20;
  localparam logic [UpcW-1:0] L_GOOD     = 5'd22;
  localparam logic [UpcW-1:0] L_BATCH    = 5'd25;
  localparam logic [UpcW-1:0] L_DIV      = 5'd27;
  localparam logic [UpcW-1:0] L_NONE     = 5'd29;

  // True for the operations that load the output register.
  function automatic logic rstm_is_emit(input rstm_op_t op);
    return (op == OP_EMIT_NONE) || (op == OP_EMIT_TO) || (op == OP_EMIT_CYC_LAST) ||
           (op == OP_EMIT_CYC_MORE) || (op == OP_EMIT_MEAN);
  endfunction

  // Builds one control word.
  function automatic rstm_uword_t rstm_uw(input rstm_op_t op, input rstm_cond_t cond,
                                          input logic inv, input logic [UpcW-1:0] target);
    rstm_uword_t w;
    w.op     = op;
    w.cond   = cond;
    w.inv    = inv;
    w.take   = 1'b0;
    w.target = target;
    return w;
  endfunction

  // Microprogram ROM. A branch is taken when the selected flag differs from inv;
  // otherwise the step counter advances. C_ALWAYS with inv set never branches.
  function automatic rstm_uword_t rstm_ucode(input logic [UpcW-1:0] addr);
    rstm_uword_t w;
    w = rstm_uw(OP_NOP, C_ALWAYS, 1'b0, L_FETCH);
    case (addr)
      // Wait for a tick, latch it and dispatch on the phase.
      5'd0: begin
        w      = rstm_uw(OP_LATCH, C_IN_VALID, 1'b1, L_FETCH);
        w.take = 1'b1;
      end
      5'd1:  w = rstm_uw(OP_NOP, C_PH_ON, 1'b0, L_ON);
      5'd2:  w = rstm_uw(OP_NOP, C_PH_SETTLE, 1'b0, L_SETTLE);
      5'd3:  w = rstm_uw(OP_NOP, C_PH_OFF, 1'b0, L_OFF);
      // Pause phase.
      5'd4:  w = rstm_uw(OP_NOP, C_TMR_GE_PAUSE, 1'b1, L_NONE);
      5'd5:  w = rstm_uw(OP_ENTER_ON, C_ALWAYS, 1'b0, L_NONE);
      // On wait phase.
      5'd6:  w = rstm_uw(OP_NOP, C_FALL, 1'b1, L_ON_TO);
      5'd7:  w = rstm_uw(OP_REC_ON, C_ALWAYS, 1'b0, L_E_SETTLE);
      5'd8:  w = rstm_uw(OP_NOP, C_TMR_GE_TO, 1'b1, L_NONE);
      5'd9:  w = rstm_uw(OP_SET_ONTO, C_ALWAYS, 1'b1, L_FETCH);
      5'd10: w = rstm_uw(OP_ENTER_SETTLE, C_SETTLE_ZERO, 1'b1, L_NONE);
      5'd11: w = rstm_uw(OP_ENTER_OFF, C_ALWAYS, 1'b0, L_NONE);
      // Settle phase.
      5'd12: w = rstm_uw(OP_NOP, C_TMR_GE_SETTLE, 1'b1, L_NONE);
      5'd13: w = rstm_uw(OP_ENTER_OFF, C_ALWAYS, 1'b0, L_NONE);
      // Off wait phase.
      5'd14: w = rstm_uw(OP_NOP, C_RISE, 1'b1, L_OFF_TO);
      5'd15: w = rstm_uw(OP_REC_OFF, C_ALWAYS, 1'b0, L_E_PAUSE);
      5'd16: w = rstm_uw(OP_NOP, C_TMR_GE_TO, 1'b1, L_NONE);
      5'd17: w = rstm_uw(OP_SET_OFFTO, C_ALWAYS, 1'b1, L_FETCH);
      // End of cycle: pause (on wait if the pause is zero), then the report.
      5'd18: w = rstm_uw(OP_ENTER_PAUSE, C_PAUSE_ZERO, 1'b1, L_CHECK);
      5'd19: w = rstm_uw(OP_ENTER_ON, C_ALWAYS, 1'b1, L_FETCH);
      5'd20: w = rstm_uw(OP_NOP, C_ERR, 1'b1, L_GOOD);
      5'd21: w = rstm_uw(OP_EMIT_TO, C_ALWAYS, 1'b0, L_FETCH);
      5'd22: w = rstm_uw(OP_ACCUM, C_ALWAYS, 1'b1, L_FETCH);
      5'd23: w = rstm_uw(OP_NOP, C_BATCH, 1'b0, L_BATCH);
      5'd24: w = rstm_uw(OP_EMIT_CYC_LAST, C_ALWAYS, 1'b0, L_FETCH);
      // Batch complete: cycle report, then divide and report the means.
      5'd25: w = rstm_uw(OP_EMIT_CYC_MORE, C_ALWAYS, 1'b1, L_FETCH);
      5'd26: w = rstm_uw(OP_DIV_INIT, C_ALWAYS, 1'b1, L_FETCH);
      5'd27: w = rstm_uw(OP_DIV_STEP, C_DIV_LAST, 1'b1, L_DIV);
      5'd28: w = rstm_uw(OP_EMIT_MEAN, C_ALWAYS, 1'b0, L_FETCH);
      // Plain tick with no report.
      5'd29: w = rstm_uw(OP_EMIT_NONE, C_ALWAYS, 1'b0, L_FETCH);
      default: w = rstm_uw(OP_NOP, C_ALWAYS, 1'b0, L_FETCH);
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/rstm_useq.sv */
// Microprogram sequencer: step counter, control ROM and branch selection.
`timescale 1ns / 1ps
`default_nettype none
module rstm_useq import rstm_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire rstm_stat_t stat,
  output rstm_ctl_t       ctl
);

  logic [UpcW-1:0] upc;
  logic [UpcW-1:0] upc_next;
  rstm_uword_t     cw;
  logic            stall;
  logic            taken;

  // Fetch the control word and resolve the branch.
  always_comb begin
    cw       = rstm_ucode(upc);
    stall    = rstm_is_emit(cw.op) && !stat.out_free;
    taken    = stat.flags[cw.cond] ^ cw.inv;
    ctl.op   = stall ? OP_NOP : cw.op;
    ctl.take = cw.take;
    if (stall) begin
      upc_next = upc;
    end else if (taken) begin
      upc_next = cw.target;
    end else begin
      upc_next = upc + 1'b1;
    end
  end

  // Step counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= L_FETCH;
    end else begin
      upc <= upc_next;
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/rstm_dpath.sv */
// Datapath: phase state, timers, measurements, sums, divider and output register.
`timescale 1ns / 1ps
`default_nettype none
`include "relay_switch_time_meter_top_assert.svh"
module rstm_dpath import rstm_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire rstm_ctl_t         ctl,
  input  wire rstm_cfg_t         cfg,
  input  wire logic              in_valid,
  input  wire logic              contact_level,
  input  wire logic              out_ready,
  output rstm_stat_t             stat,
  output logic                   out_valid,
  output logic                   relay_drive,
  output logic [1:0]             report_kind,
  output logic [TimeW-1:0]       on_time,
  output logic [TimeW-1:0]       off_time,
  output logic [CountW-1:0]      cycle_index,
  output logic                   on_timed_out,
  output logic                   off_timed_out,
  output logic                   last
);

  typedef enum logic [1:0] {
    PH_ON_WAIT  = 2'd0,
    PH_SETTLE   = 2'd1,
    PH_OFF_WAIT = 2'd2,
    PH_PAUSE    = 2'd3
  } phase_t;

  phase_t             phase;
  logic [TimerW-1:0]  phase_timer;
  logic               previous_level;
  logic               fall;
  logic               rise;
  logic [TimeW-1:0]   measured_on;
  logic [TimeW-1:0]   measured_off;
  logic               on_pending;
  logic               off_to;
  logic [SumW-1:0]    on_sum;
  logic [SumW-1:0]    off_sum;
  logic [CountW-1:0]  good_cycles;
  logic [CountW-1:0]  good_next;

  // Divider: quotient builds in place of the dividend, one bit per step.
  logic [SumW-1:0]    div_on_q;
  logic [SumW-1:0]    div_off_q;
  logic [CountW-1:0]  div_on_rem;
  logic [CountW-1:0]  div_off_rem;
  logic [DivCntW-1:0] div_cnt;
  logic [CountW:0]    on_part;
  logic [CountW:0]    off_part;
  logic               on_ge;
  logic               off_ge;
  logic [CountW:0]    on_diff;
  logic [CountW:0]    off_diff;

  rstm_rep_t          rep_kind;
  logic               relay_now;
  logic               accepted;

  // Terms used by the checks at the end of the module.
  logic               mean_out;
  logic               to_out;
  logic               batch_clear;

  assign accepted  = ctl.take && in_valid;
  assign relay_now = (phase == PH_ON_WAIT) || (phase == PH_SETTLE);
  assign good_next = good_cycles + 1'b1;

  // One restoring-division step for both sums against the same divisor.
  always_comb begin
    on_part  = {div_on_rem, div_on_q[SumW-1]};
    off_part = {div_off_rem, div_off_q[SumW-1]};
    on_ge    = on_part >= {1'b0, good_cycles};
    off_ge   = off_part >= {1'b0, good_cycles};
    on_diff  = on_part - {1'b0, good_cycles};
    off_diff = off_part - {1'b0, good_cycles};
  end

  // Status flags for the sequencer's branches.
  always_comb begin
    stat.flags                  = '0;
    stat.flags[C_ALWAYS]        = 1'b1;
    stat.flags[C_IN_VALID]      = in_valid;
    stat.flags[C_PH_ON]         = phase == PH_ON_WAIT;
    stat.flags[C_PH_SETTLE]     = phase == PH_SETTLE;
    stat.flags[C_PH_OFF]        = phase == PH_OFF_WAIT;
    stat.flags[C_FALL]          = fall;
    stat.flags[C_RISE]          = rise;
    stat.flags[C_TMR_GE_TO]     = phase_timer >= {1'b0, cfg.timeout_ticks};
    stat.flags[C_TMR_GE_SETTLE] = phase_timer >= cfg.settle_ticks;
    stat.flags[C_TMR_GE_PAUSE]  = phase_timer >= cfg.pause_ticks;
    stat.flags[C_SETTLE_ZERO]   = cfg.settle_ticks == '0;
    stat.flags[C_PAUSE_ZERO]    = cfg.pause_ticks == '0;
    stat.flags[C_ERR]           = on_pending || off_to;
    stat.flags[C_BATCH]         = (good_cycles != '0) && (good_cycles >= cfg.batch_size);
    stat.flags[C_DIV_LAST]      = div_cnt == DivLast;
    stat.out_free               = !out_valid || out_ready;
  end

  // Micro-operation execution and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_ON_WAIT;
      phase_timer    <= '0;
      previous_level <= 1'b1;
      fall           <= 1'b0;
      rise           <= 1'b0;
      measured_on    <= '0;
      measured_off   <= '0;
      on_pending     <= 1'b0;
      off_to         <= 1'b0;
      on_sum         <= '0;
      off_sum        <= '0;
      good_cycles    <= '0;
      div_cnt        <= '0;
      out_valid      <= 1'b0;
    end else begin
      // A report loads only when the register is free, so valid holds or reloads here.
      out_valid <= rstm_is_emit(ctl.op) || (out_valid && !out_ready);
      case (ctl.op)
        OP_LATCH: begin
          if (accepted) begin
            fall           <= previous_level && !contact_level;
            rise           <= !previous_level && contact_level;
            previous_level <= contact_level;
            phase_timer    <= phase_timer + 1'b1;
            off_to         <= 1'b0;
          end
        end
        OP_ENTER_ON: begin
          phase       <= PH_ON_WAIT;
          phase_timer <= '0;
        end
        OP_ENTER_SETTLE: begin
          phase       <= PH_SETTLE;
          phase_timer <= '0;
        end
        OP_ENTER_OFF: begin
          phase       <= PH_OFF_WAIT;
          phase_timer <= '0;
        end
        OP_ENTER_PAUSE: begin
          phase       <= PH_PAUSE;
          phase_timer <= '0;
        end
        OP_REC_ON: begin
          measured_on <= phase_timer[TimeW-1:0];
          on_pending  <= 1'b0;
        end
        OP_SET_ONTO: begin
          on_pending <= 1'b1;
        end
        OP_REC_OFF: begin
          measured_off <= phase_timer[TimeW-1:0];
        end
        OP_SET_OFFTO: begin
          off_to <= 1'b1;
        end
        OP_ACCUM: begin
          on_sum      <= on_sum + {{(SumW-TimeW){1'b0}}, measured_on};
          off_sum     <= off_sum + {{(SumW-TimeW){1'b0}}, measured_off};
          good_cycles <= good_next;
        end
        OP_DIV_INIT: begin
          div_on_q    <= on_sum;
          div_off_q   <= off_sum;
          div_on_rem  <= '0;
          div_off_rem <= '0;
          div_cnt     <= '0;
        end
        OP_DIV_STEP: begin
          div_on_rem  <= on_ge ? on_diff[CountW-1:0] : on_part[CountW-1:0];
          div_off_rem <= off_ge ? off_diff[CountW-1:0] : off_part[CountW-1:0];
          div_on_q    <= {div_on_q[SumW-2:0], on_ge};
          div_off_q   <= {div_off_q[SumW-2:0], off_ge};
          div_cnt     <= div_cnt + 1'b1;
        end
        OP_EMIT_NONE: begin
          relay_drive   <= relay_now;
          rep_kind      <= REP_NONE;
          on_time       <= '0;
          off_time      <= '0;
          cycle_index   <= '0;
          on_timed_out  <= 1'b0;
          off_timed_out <= 1'b0;
          last          <= 1'b1;
        end
        OP_EMIT_TO: begin
          relay_drive   <= relay_now;
          rep_kind      <= REP_TIMEOUT;
          on_time       <= '0;
          off_time      <= '0;
          cycle_index   <= good_cycles;
          on_timed_out  <= on_pending;
          off_timed_out <= off_to;
          last          <= 1'b1;
        end
        OP_EMIT_CYC_LAST, OP_EMIT_CYC_MORE: begin
          relay_drive   <= relay_now;
          rep_kind      <= REP_CYCLE;
          on_time       <= measured_on;
          off_time      <= measured_off;
          cycle_index   <= good_cycles;
          on_timed_out  <= 1'b0;
          off_timed_out <= 1'b0;
          last          <= ctl.op == OP_EMIT_CYC_LAST;
        end
        OP_EMIT_MEAN: begin
          relay_drive   <= relay_now;
          rep_kind      <= REP_MEAN;
          on_time       <= div_on_q[TimeW-1:0];
          off_time      <= div_off_q[TimeW-1:0];
          cycle_index   <= good_cycles;
          on_timed_out  <= 1'b0;
          off_timed_out <= 1'b0;
          last          <= 1'b1;
          on_sum        <= '0;
          off_sum       <= '0;
          good_cycles   <= '0;
        end
        default: begin
        end
      endcase
    end
  end

  assign report_kind = rep_kind;

  assign mean_out    = out_valid && (rep_kind == REP_MEAN);
  assign to_out      = out_valid && (rep_kind == REP_TIMEOUT);
  assign batch_clear = (good_cycles == '0) && (on_sum == '0) && (off_sum == '0);

  // The divisor is never zero while the divider runs.
  `RSTM_ASSERT_IMP(a_div_nonzero, clk, rst, ctl.op == OP_DIV_STEP, good_cycles != '0, "zero divisor")
  // A means report is always the final result of its tick and has a nonzero cycle index.
  `RSTM_ASSERT_IMP(a_mean_last, clk, rst, mean_out, last && (cycle_index != '0), "bad means report")
  // A timeout report names at least one phase.
  `RSTM_ASSERT_IMP(a_to_flag, clk, rst, to_out, on_timed_out || off_timed_out, "timeout without flag")
  // Sums and count clear once the means are issued.
  `RSTM_ASSERT_NXT(a_batch_clear, clk, rst, ctl.op == OP_EMIT_MEAN, batch_clear, "batch not cleared")

endmodule
`default_nettype wire

/* hw/rtl/relay_switch_time_meter_top.sv */
// Top level of the relay switching-time meter: configuration registers and core.
//
//   Channel   Direction  Handshake               Payload
//   in        to block   in_valid / in_ready     contact_level
//   out       from block out_valid / out_ready   relay_drive, report_kind, on_time,
//                                                off_time, cycle_index, on_timed_out,
//                                                off_timed_out, last
//   cfg       to block   APB psel/penable/pready timeout, settle, pause, batch size
//
// The time from a tick's acceptance to its result is set by the microprogram path through
// the control ROM; a tick that completes a batch also runs the 28-step shared restoring
// divider for the two means.
// The next tick is accepted once the microprogram returns to its fetch step.
// A result waiting in the output register stalls the sequencer only at its next report.
// Reset is synchronous; it returns the registers to their defaults and the phase to on wait.
`timescale 1ns / 1ps
`default_nettype none
module relay_switch_time_meter_top import rstm_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  // Tick input
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic              contact_level,
  // Results
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic                   relay_drive,
  output logic [1:0]             report_kind,
  output logic [TimeW-1:0]       on_time,
  output logic [TimeW-1:0]       off_time,
  output logic [CountW-1:0]      cycle_index,
  output logic                   on_timed_out,
  output logic                   off_timed_out,
  output logic                   last,
  // Configuration
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [AddrW-1:0]  paddr,
  input  wire logic [DataW-1:0]  pwdata,
  output logic [DataW-1:0]       prdata,
  output logic                   pready
);

  rstm_cfg_t  cfg;
  rstm_ctl_t  ctl;
  rstm_stat_t stat;
  rstm_reg_t  reg_sel;
  logic       cfg_write;

  assign pready    = 1'b1;
  assign reg_sel   = rstm_reg_t'(paddr[3:2]);
  assign cfg_write = psel && penable && pwrite && pready;
  assign in_ready  = ctl.take;

  // Configuration register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.timeout_ticks <= TimeoutReset;
      cfg.settle_ticks  <= SettleReset;
      cfg.pause_ticks   <= PauseReset;
      cfg.batch_size    <= BatchReset;
    end else if (cfg_write) begin
      case (reg_sel)
        REG_TIMEOUT: cfg.timeout_ticks <= pwdata[TimeW-1:0];
        REG_SETTLE:  cfg.settle_ticks  <= pwdata[TimerW-1:0];
        REG_PAUSE:   cfg.pause_ticks   <= pwdata[TimerW-1:0];
        REG_BATCH:   cfg.batch_size    <= pwdata[CountW-1:0];
        default: begin
        end
      endcase
    end
  end

  // Configuration readback.
  always_comb begin
    case (reg_sel)
      REG_TIMEOUT: prdata = {{(DataW-TimeW){1'b0}}, cfg.timeout_ticks};
      REG_SETTLE:  prdata = {{(DataW-TimerW){1'b0}}, cfg.settle_ticks};
      REG_PAUSE:   prdata = {{(DataW-TimerW){1'b0}}, cfg.pause_ticks};
      REG_BATCH:   prdata = {{(DataW-CountW){1'b0}}, cfg.batch_size};
      default:     prdata = '0;
    endcase
  end

  rstm_useq u_useq (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .ctl  (ctl)
  );

  rstm_dpath u_dpath (
    .clk           (clk),
    .rst           (rst),
    .ctl           (ctl),
    .cfg           (cfg),
    .in_valid      (in_valid),
    .contact_level (contact_level),
    .out_ready     (out_ready),
    .stat          (stat),
    .out_valid     (out_valid),
    .relay_drive   (relay_drive),
    .report_kind   (report_kind),
    .on_time       (on_time),
    .off_time      (off_time),
    .cycle_index   (cycle_index),
    .on_timed_out  (on_timed_out),
    .off_timed_out (off_timed_out),
    .last          (last)
  );

endmodule
`default_nettype wire
